// ===== src/nfca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and frame constants for the ISO 14443-A activation block.
// No dependencies; used by the channel interfaces, nfca_ctrl and the top level.
package nfca_pkg;

	localparam int unsigned MaxCascadeLevelsDef = 3;

	// event kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_FAULT = 2'd2;

	typedef enum logic [2:0] {
		ACT_REQA     = 3'd0,
		ACT_ANTICOLL = 3'd1,
		ACT_SELECT   = 3'd2,
		ACT_HLTA     = 3'd3,
		ACT_DONE     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_PRESENT = 2'd1,
		ST_COMM_ERR   = 2'd2,
		ST_COLRES_ERR = 2'd3
	} status_t;

	localparam logic [7:0] REQA_BYTE     = 8'h26;
	localparam logic [7:0] HLTA_BYTE     = 8'h50;
	localparam logic [7:0] NVB_ANTICOLL  = 8'h20;
	localparam logic [7:0] NVB_SELECT    = 8'h70;
	localparam logic [7:0] SEL_BASE      = 8'h93;
	localparam logic [7:0] CASCADE_TAG   = 8'h88;
	localparam logic [2:0] LEN_ATQA      = 3'd2;
	localparam logic [2:0] LEN_SDD       = 3'd5;
	localparam logic [2:0] LEN_SAK       = 3'd1;
	localparam logic [2:0] TXLEN_REQA    = 3'd1;
	localparam logic [2:0] TXLEN_SHORT   = 3'd2;
	localparam logic [2:0] TXLEN_SELECT  = 3'd7;
	localparam int unsigned UidOutBytes  = 10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  rx_len;
		logic [39:0] rx_data;
		logic        crc_ok;
	} evt_t;

	typedef struct packed {
		action_t     action;
		logic [2:0]  tx_len;
		logic [55:0] tx_data;
		status_t     status;
		logic [15:0] atqa;
		logic [7:0]  sak;
		logic [3:0]  uid_length;
		logic [63:0] uid_low;
		logic [15:0] uid_high;
	} res_t;

	// SEL code: 0x93, 0x95, 0x97 by cascade level
	function automatic logic [7:0] sel_code(input logic [1:0] level);
		sel_code = SEL_BASE + {5'd0, level, 1'b0};
	endfunction

endpackage : nfca_pkg
`default_nettype wire

// ===== src/nfca_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces: event channel and result channel.
// Depends on nfca_pkg for the action and status codes.
interface nfca_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  rx_len;
	logic [39:0] rx_data;
	logic        crc_ok;

	modport source (output valid, kind, rx_len, rx_data, crc_ok, input ready);
	modport sink (input valid, kind, rx_len, rx_data, crc_ok, output ready);
endinterface : nfca_evt_if

interface nfca_rsp_if;
	logic                 valid;
	logic                 ready;
	nfca_pkg::action_t    action;
	logic [2:0]           tx_len;
	logic [55:0]          tx_data;
	nfca_pkg::status_t    status;
	logic [15:0]          atqa;
	logic [7:0]           sak;
	logic [3:0]           uid_length;
	logic [63:0]          uid_low;
	logic [15:0]          uid_high;

	modport source (output valid, action, tx_len, tx_data, status, atqa, sak, uid_length,
		uid_low, uid_high, input ready);
	modport sink (input valid, action, tx_len, tx_data, status, atqa, sak, uid_length,
		uid_low, uid_high, output ready);
endinterface : nfca_rsp_if
`default_nettype wire

// ===== src/nfca_anticollision_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ISO 14443-A reader activation (REQA, anticollision, SELECT over cascade levels).
// Depends on nfca_pkg, nfca_if.sv and nfca_ctrl.
//
// Usage:
//  evt : transceiver events in (start, frame received with CRC check result, timeout).
//  rsp : one result per event at most: a frame to send (REQA, anticollision,
//        SELECT, HLTA) or "finished" with status, ATQA, SAK and UID.
//  An event is taken into an input register; once the output register is free the
//  sequencer works it out in a single pass and the result lands in the output register.
//  One event per cycle is sustained, limited only by the output register being free.
//  Events that produce nothing (stray frames, kind 3) still take their slot.
//  When rsp is stalled the output register holds, the input register holds its
//  event, and evt.ready drops once both are full; nothing is dropped.
//  Reset clears the phase to idle and all card data to zero; the UID byte store
//  has no reset and is masked by the byte count.
module nfca_anticollision_select #(
	parameter int unsigned MAX_CASCADE_LEVELS = nfca_pkg::MaxCascadeLevelsDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nfca_evt_if.sink   evt,
	nfca_rsp_if.source rsp
);
	import nfca_pkg::*;

	logic   valid_s1;
	evt_t   evt_s1;
	logic   adv;
	logic   has_res;
	res_t   res;
	logic   rsp_valid_q;
	res_t   rsp_q;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign evt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= '{kind: evt.kind, rx_len: evt.rx_len, rx_data: evt.rx_data,
				crc_ok: evt.crc_ok};
		end
	end

	nfca_ctrl #(
		.MAX_CASCADE_LEVELS(MAX_CASCADE_LEVELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.evt     (evt_s1),
		.has_res (has_res),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= has_res;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.action     = rsp_q.action;
	assign rsp.tx_len     = rsp_q.tx_len;
	assign rsp.tx_data    = rsp_q.tx_data;
	assign rsp.status     = rsp_q.status;
	assign rsp.atqa       = rsp_q.atqa;
	assign rsp.sak        = rsp_q.sak;
	assign rsp.uid_length = rsp_q.uid_length;
	assign rsp.uid_low    = rsp_q.uid_low;
	assign rsp.uid_high   = rsp_q.uid_high;

`ifndef ASSERT_OFF
	a_held_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("pending event lost");
	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		adv && has_res |=> rsp.valid)
		else $error("result not presented");
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> evt.ready)
		else $error("input stalled with empty stage");
`endif
endmodule : nfca_anticollision_select
`default_nettype wire

// ===== src/nfca_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Activation sequencer: phase, cascade level and card data registers, plus the
// single-pass logic that turns one registered event into at most one result. Uses nfca_pkg.
module nfca_ctrl #(
	parameter int unsigned MAX_CASCADE_LEVELS = nfca_pkg::MaxCascadeLevelsDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  nfca_pkg::evt_t      evt,
	output logic                has_res,
	output nfca_pkg::res_t      res
);
	import nfca_pkg::*;

	localparam int unsigned UidBytes = 3 * MAX_CASCADE_LEVELS + 1;
	localparam int unsigned IdxW = $clog2(UidBytes);

	typedef enum logic [2:0] {
		PH_IDLE, PH_WAIT_ATQA, PH_WAIT_SDD, PH_WAIT_SAK,
		PH_ACTIVATED, PH_FAILED, PH_WAIT_HALT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  level_q, level_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [15:0] atqa_q, atqa_d;
	logic [7:0]  sak_q, sak_d;
	logic [39:0] id_q, id_d;
	logic [7:0]  uid_q [UidBytes];
	logic [7:0]  uid_d [UidBytes];

	logic        frame;
	logic        wr_en;
	logic        wr_skip_tag;
	logic [31:0] wr_src;
	logic [3:0]  wr_n;
	logic [3:0]  rel;
	logic        done_ok;
	logic [7:0]  ob;

	always_comb begin
		frame       = (evt.kind == KIND_FRAME);
		phase_d     = phase_q;
		level_d     = level_q;
		cnt_d       = cnt_q;
		atqa_d      = atqa_q;
		sak_d       = sak_q;
		id_d        = id_q;
		has_res     = 1'b0;
		res         = '0;
		wr_en       = 1'b0;
		wr_skip_tag = 1'b0;
		done_ok     = 1'b0;
		ob          = '0;

		if (evt.kind == KIND_START) begin
			has_res = 1'b1;
			if (phase_q == PH_ACTIVATED) begin
				res.action = ACT_DONE;
				done_ok    = 1'b1;
			end else begin
				level_d = '0;
				cnt_d   = '0;
				atqa_d  = '0;
				sak_d   = '0;
				id_d    = '0;
				if (phase_q == PH_IDLE || phase_q == PH_WAIT_ATQA) begin
					phase_d     = PH_WAIT_ATQA;
					res.action  = ACT_REQA;
					res.tx_len  = TXLEN_REQA;
					res.tx_data = {48'd0, REQA_BYTE};
				end else begin
					phase_d     = PH_WAIT_HALT;
					res.action  = ACT_HLTA;
					res.tx_len  = TXLEN_SHORT;
					res.tx_data = {48'd0, HLTA_BYTE};
				end
			end
		end else if (evt.kind == KIND_FRAME || evt.kind == KIND_FAULT) begin
			case (phase_q)
				PH_WAIT_HALT: begin
					has_res     = 1'b1;
					phase_d     = PH_WAIT_ATQA;
					res.action  = ACT_REQA;
					res.tx_len  = TXLEN_REQA;
					res.tx_data = {48'd0, REQA_BYTE};
				end
				PH_WAIT_ATQA: begin
					has_res = 1'b1;
					if (!frame) begin
						phase_d    = PH_IDLE;
						res.action = ACT_DONE;
						res.status = ST_NOT_PRESENT;
					end else if (evt.rx_len != LEN_ATQA) begin
						phase_d    = PH_IDLE;
						res.action = ACT_DONE;
						res.status = ST_COMM_ERR;
					end else begin
						atqa_d      = evt.rx_data[15:0];
						level_d     = '0;
						phase_d     = PH_WAIT_SDD;
						res.action  = ACT_ANTICOLL;
						res.tx_len  = TXLEN_SHORT;
						res.tx_data = {40'd0, NVB_ANTICOLL, sel_code(2'd0)};
					end
				end
				PH_WAIT_SDD: begin
					has_res = 1'b1;
					if (!frame || evt.rx_len != LEN_SDD) begin
						phase_d    = PH_FAILED;
						res.action = ACT_DONE;
						res.status = ST_COLRES_ERR;
					end else begin
						id_d        = evt.rx_data;
						phase_d     = PH_WAIT_SAK;
						res.action  = ACT_SELECT;
						res.tx_len  = TXLEN_SELECT;
						res.tx_data = {evt.rx_data, NVB_SELECT, sel_code(level_q)};
					end
				end
				PH_WAIT_SAK: begin
					has_res = 1'b1;
					if (!frame || !evt.crc_ok || evt.rx_len != LEN_SAK ||
						(id_q[7:0] == CASCADE_TAG &&
						 32'(level_q) + 32'd1 >= 32'(MAX_CASCADE_LEVELS))) begin
						phase_d    = PH_FAILED;
						res.action = ACT_DONE;
						res.status = ST_COLRES_ERR;
					end else if (id_q[7:0] == CASCADE_TAG) begin
						// cascade tag: keep three id bytes, go one level down
						wr_en       = 1'b1;
						wr_skip_tag = 1'b1;
						level_d     = level_q + 2'd1;
						phase_d     = PH_WAIT_SDD;
						res.action  = ACT_ANTICOLL;
						res.tx_len  = TXLEN_SHORT;
						res.tx_data = {40'd0, NVB_ANTICOLL, sel_code(level_q + 2'd1)};
					end else begin
						wr_en      = 1'b1;
						sak_d      = evt.rx_data[7:0];
						phase_d    = PH_ACTIVATED;
						res.action = ACT_DONE;
						done_ok    = 1'b1;
					end
				end
				default: begin
					has_res = 1'b0;
				end
			endcase
		end

		// UID byte append
		wr_src = wr_skip_tag ? {8'd0, id_q[31:8]} : id_q[31:0];
		wr_n   = wr_skip_tag ? 4'd3 : 4'd4;
		for (int i = 0; i < UidBytes; i++) begin
			rel      = 4'(i) - cnt_q;
			uid_d[i] = uid_q[i];
			if (wr_en && 4'(i) >= cnt_q && rel < wr_n) begin
				uid_d[i] = wr_src[8 * rel[1:0] +: 8];
			end
		end
		if (wr_en) begin
			cnt_d = cnt_q + wr_n;
		end

		if (done_ok) begin
			res.atqa       = atqa_d;
			res.sak        = sak_d;
			res.uid_length = cnt_d;
			for (int i = 0; i < UidOutBytes; i++) begin
				ob = '0;
				if (i < UidBytes && 4'(i) < cnt_d) begin
					ob = uid_d[IdxW'(i)];
				end
				if (i < 8) begin
					res.uid_low[8 * i +: 8] = ob;
				end else begin
					res.uid_high[8 * (i - 8) +: 8] = ob;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			level_q <= '0;
			cnt_q   <= '0;
			atqa_q  <= '0;
			sak_q   <= '0;
			id_q    <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			level_q <= level_d;
			cnt_q   <= cnt_d;
			atqa_q  <= atqa_d;
			sak_q   <= sak_d;
			id_q    <= id_d;
		end
	end

	// UID bytes hold no reset value; bytes at or past the count are masked
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < UidBytes; i++) begin
				uid_q[i] <= uid_d[i];
			end
		end
	end

`ifndef ASSERT_OFF
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(level_q) < 32'(MAX_CASCADE_LEVELS))
		else $error("cascade level beyond configured depth");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= UidBytes)
		else $error("uid count beyond storage");
	a_activated_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ACTIVATED |-> (cnt_q == 4'd4 || cnt_q == 4'd7 || cnt_q == 4'd10))
		else $error("activated with a partial uid");
`endif
endmodule : nfca_ctrl
`default_nettype wire
